>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define BPA_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies a condition in the next
`define BPA_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg
// types, constants and helper functions of the buddy page allocator
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int NUM_ORDERS = 11;
  localparam int TOP_ORDER  = NUM_ORDERS - 1;
  localparam int ORD_W      = $clog2(NUM_ORDERS + 1);
  localparam int BLK_W      = TOP_ORDER + 1;
  localparam int UW         = 16;
  localparam int UW_SH      = $clog2(UW);
  localparam int UWA_W      = PAGE_W - UW_SH;
  localparam int UWORDS     = MAX_PAGES / UW;
  localparam int PC_W       = $clog2(UW + 1);

  localparam logic [1:0] FN_INIT  = 2'd0;
  localparam logic [1:0] FN_ALLOC = 2'd1;
  localparam logic [1:0] FN_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_FIRST = 1'b1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_CARVE, S_SCAN, S_TAKE, S_TAKE_RD, S_TAKE_WR,
    S_SPLIT, S_SPLIT_RD, S_SPLIT_WR, S_CHK_RD, S_CHK_WR, S_REL_RD, S_REL_WR,
    S_USE_RD, S_USE_WR, S_MERGE, S_BUD_RD, S_BUD_WR, S_FILE_RD, S_FILE_WR,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CLR_START, CMD_CLR_STEP, CMD_CARVE_BLOCK,
    CMD_SCAN_START, CMD_SCAN_STEP, CMD_TAKE, CMD_MWR_CLR, CMD_MWR_SET,
    CMD_MERGE, CMD_SPLIT_DEC, CMD_RNG_PG, CMD_RNG_BLK, CMD_RNG_CHK,
    CMD_RNG_REL
  } cmd_t;

  typedef enum logic [1:0] {TGT_SELF, TGT_HALF, TGT_BUDDY} tgt_t;

  typedef struct packed {
    cmd_t       cmd;
    tgt_t       tgt;
    logic       use_pass;  // range write marks pages used
    logic [1:0] st;
  } ctl_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cnt_zero;
    logic       ord_big;
    logic       free_bad;
    logic       clr_last;
    logic       carve_done;
    logic       scan_done;
    logic       scan_none;
    logic       at_want;
    logic       at_top;
    logic       bud_hit;
    logic       rng_last;
    logic       chk_fail;
    logic       out_free;
  } sts_t;

  // smallest order whose block holds n pages, NUM_ORDERS when none does
  function automatic logic [ORD_W-1:0] order_for(input logic [CNT_W-1:0] n);
    logic [ORD_W-1:0] o;
    o = ORD_W'(NUM_ORDERS);
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if ({1'b0, n} <= ((CNT_W+1)'(1) << i)) o = ORD_W'(i);
    end
    return o;
  endfunction

  function automatic logic [ORD_W-1:0] lowest_set(input logic [NUM_ORDERS-1:0] v);
    logic [ORD_W-1:0] o;
    o = ORD_W'(NUM_ORDERS);
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if (v[i]) o = ORD_W'(i);
    end
    return o;
  endfunction

  function automatic logic [PC_W-1:0] popcnt(input logic [UW-1:0] v);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < UW; i++) c = c + PC_W'(v[i]);
    return c;
  endfunction

endpackage

>>> hdl/bpa_ram.sv
// ---------------------------------------------------------------------------
// bpa_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bpa_dp.sv
// ---------------------------------------------------------------------------
// bpa_dp
// allocator datapath: block marks ram, page used ram, counters, result word
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bpa_dp
  import bpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  input  logic [1:0]           in_func,
  input  logic [CNT_W-1:0]     in_count,
  input  logic [PAGE_W-1:0]    in_page,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [CNT_W-1:0]     cfg_val,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [1:0]           out_status,
  output logic [PAGE_W-1:0]    out_block_page,
  output logic [BLK_W-1:0]     out_blk_len,
  output logic [CNT_W-1:0]     out_free_count
);

  logic [CNT_W-1:0]      total_r, first_r, end_w;
  logic [1:0]            func_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [PAGE_W-1:0]     pg_r;
  logic [ORD_W-1:0]      want_r;
  logic [CNT_W-1:0]      free_cnt_r;
  logic [PAGE_W-1:0]     clr_r;
  logic [CNT_W-1:0]      p_r;
  logic [ORD_W-1:0]      co_w;
  logic [CNT_W-1:0]      co_sz;
  logic [CNT_W-1:0]      rfirst_r, rend_r, rlast_pg;
  logic [UWA_W-1:0]      rw_r;
  logic [UW-1:0]         mask_w;
  logic [PAGE_W-1:0]     addr_r;
  logic [ORD_W-1:0]      ord_r;
  logic [PAGE_W-1:0]     scan_a_r, scan_q_r, best_p_r;
  logic                  scan_v_r;
  logic [ORD_W-1:0]      best_o_r, lo_w;
  logic [NUM_ORDERS-1:0] scan_m;
  logic [CNT_W-1:0]      sz_w, pg_ext, blk_sz;
  logic [PAGE_W-1:0]     oh_w, tgt_addr;
  logic [NUM_ORDERS-1:0] bit_w;
  logic [PC_W-1:0]       pc_rel, pc_use;

  logic                  m_we;
  logic [PAGE_W-1:0]     m_waddr, m_raddr;
  logic [NUM_ORDERS-1:0] m_wdata, m_rdata;
  logic                  u_we;
  logic [UWA_W-1:0]      u_waddr;
  logic [UW-1:0]         u_wdata, u_rdata;

  logic                  out_tvalid_r;
  logic [1:0]            out_status_r;
  logic [PAGE_W-1:0]     out_block_page_r;
  logic [BLK_W-1:0]      out_blk_len_r;
  logic [CNT_W-1:0]      out_free_count_r;

  bpa_ram #(.WIDTH(NUM_ORDERS), .DEPTH(MAX_PAGES)) u_marks (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  bpa_ram #(.WIDTH(UW), .DEPTH(UWORDS)) u_used (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(rw_r), .rdata(u_rdata)
  );

  assign end_w  = (total_r > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_r;
  assign sz_w   = CNT_W'(1) << want_r;
  assign pg_ext = CNT_W'(pg_r);
  assign blk_sz = CNT_W'(1) << want_r;

  // largest aligned block at the carve pointer that still fits below the end
  always_comb begin
    co_w = '0;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      if (((p_r & (CNT_W'(1 << i) - CNT_W'(1))) == '0) &&
          ({1'b0, p_r} + ((CNT_W+1)'(1) << i) <= {1'b0, end_w}))
        co_w = ORD_W'(i);
    end
  end
  assign co_sz = CNT_W'(1) << co_w;

  // pages of the current used-bit word inside the range and the managed span
  always_comb begin
    logic [CNT_W-1:0] pg;
    for (int j = 0; j < UW; j++) begin
      pg = CNT_W'({rw_r, UW_SH'(j)});
      mask_w[j] = (pg >= rfirst_r) && (pg < rend_r) && (pg < end_w);
    end
  end
  assign rlast_pg = rend_r - CNT_W'(1);
  assign pc_rel   = popcnt(u_rdata & mask_w);
  assign pc_use   = popcnt(mask_w & ~u_rdata);

  assign oh_w  = PAGE_W'(1) << ord_r;
  assign bit_w = NUM_ORDERS'(1) << ord_r;
  always_comb begin
    unique case (ctl.tgt)
      TGT_HALF:  tgt_addr = addr_r | oh_w;
      TGT_BUDDY: tgt_addr = addr_r ^ oh_w;
      default:   tgt_addr = addr_r;
    endcase
  end

  assign scan_m = m_rdata & ~((NUM_ORDERS'(1) << want_r) - NUM_ORDERS'(1));
  assign lo_w   = lowest_set(scan_m);

  // memory ports
  always_comb begin
    m_raddr = (ctl.cmd == CMD_SCAN_STEP) ? scan_a_r : tgt_addr;
    m_we    = 1'b0;
    m_waddr = tgt_addr;
    m_wdata = m_rdata & ~bit_w;
    u_we    = 1'b0;
    u_waddr = rw_r;
    u_wdata = u_rdata & ~mask_w;
    unique case (ctl.cmd)
      CMD_CLR_STEP: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
        u_we    = (clr_r < PAGE_W'(UWORDS));
        u_waddr = clr_r[UWA_W-1:0];
        u_wdata = '1;
      end
      CMD_CARVE_BLOCK: begin
        m_we    = 1'b1;
        m_waddr = p_r[PAGE_W-1:0];
        m_wdata = NUM_ORDERS'(1) << co_w;
      end
      CMD_MWR_CLR, CMD_MERGE: m_we = 1'b1;
      CMD_MWR_SET: begin
        m_we    = 1'b1;
        m_wdata = m_rdata | bit_w;
      end
      CMD_RNG_REL: begin
        u_we    = 1'b1;
        u_wdata = ctl.use_pass ? (u_rdata | mask_w) : (u_rdata & ~mask_w);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      first_r      <= '0;
      free_cnt_r   <= '0;
      clr_r        <= '0;
      scan_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TOTAL: total_r <= cfg_val;
          CFG_FIRST: first_r <= cfg_val;
          default: ;
        endcase
      end
      unique case (ctl.cmd)
        CMD_CLR_START: begin
          clr_r      <= '0;
          free_cnt_r <= '0;
        end
        CMD_CLR_STEP:   clr_r    <= clr_r + PAGE_W'(1);
        CMD_SCAN_START: scan_v_r <= 1'b0;
        CMD_SCAN_STEP:  scan_v_r <= 1'b1;
        CMD_RNG_REL: begin
          if (ctl.use_pass)
            free_cnt_r <= (free_cnt_r > CNT_W'(pc_use)) ? free_cnt_r - CNT_W'(pc_use) : '0;
          else
            free_cnt_r <= free_cnt_r + CNT_W'(pc_rel);
        end
        default: ;
      endcase
      if (ctl.cmd == CMD_NONE && ctl.use_pass && ctl.tgt == TGT_SELF) out_tvalid_r <= 1'b1;
      else out_tvalid_r <= out_tvalid_r && !out_tready;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_LOAD: begin
        func_r <= in_func;
        cnt_r  <= in_count;
        pg_r   <= in_page;
        want_r <= order_for(in_count);
      end
      CMD_CLR_STEP: p_r <= first_r;
      CMD_CARVE_BLOCK: begin
        rfirst_r <= p_r;
        rend_r   <= p_r + co_sz;
        rw_r     <= p_r[PAGE_W-1:UW_SH];
        p_r      <= p_r + co_sz;
      end
      CMD_SCAN_START: begin
        scan_a_r <= '0;
        best_o_r <= ORD_W'(NUM_ORDERS);
      end
      CMD_SCAN_STEP: begin
        scan_a_r <= scan_a_r + PAGE_W'(1);
        scan_q_r <= scan_a_r;
        if (scan_v_r && (|scan_m) && (lo_w < best_o_r)) begin
          best_o_r <= lo_w;
          best_p_r <= scan_q_r;
        end
      end
      CMD_TAKE: begin
        addr_r <= best_p_r;
        ord_r  <= best_o_r;
      end
      CMD_MERGE: begin
        addr_r <= addr_r & ~oh_w;
        ord_r  <= ord_r + ORD_W'(1);
      end
      CMD_SPLIT_DEC: ord_r <= ord_r - ORD_W'(1);
      CMD_RNG_PG: begin
        rfirst_r <= pg_ext;
        rend_r   <= pg_ext + sz_w;
        rw_r     <= pg_r[PAGE_W-1:UW_SH];
        addr_r   <= pg_r;
        ord_r    <= want_r;
      end
      CMD_RNG_BLK: begin
        rfirst_r <= CNT_W'(addr_r);
        rend_r   <= CNT_W'(addr_r) + blk_sz;
        rw_r     <= addr_r[PAGE_W-1:UW_SH];
      end
      CMD_RNG_CHK, CMD_RNG_REL: rw_r <= rw_r + UWA_W'(1);
      default: ;
    endcase
    if (ctl.cmd == CMD_NONE && ctl.use_pass && ctl.tgt == TGT_SELF) begin
      out_status_r      <= ctl.st;
      out_block_page_r  <= (ctl.st == ST_OK && func_r == FN_ALLOC) ? addr_r : '0;
      out_blk_len_r     <= (ctl.st == ST_OK && func_r != FN_INIT) ?
                           (BLK_W'(1) << want_r) : '0;
      out_free_count_r  <= free_cnt_r;
    end
  end

  assign sts.func       = func_r;
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.ord_big    = (want_r >= ORD_W'(NUM_ORDERS));
  assign sts.free_bad   = (cnt_r == '0) || (pg_r == '0) || (want_r >= ORD_W'(NUM_ORDERS)) ||
                          ((pg_ext & (sz_w - CNT_W'(1))) != '0) ||
                          ({1'b0, pg_ext} + {1'b0, sz_w} > {1'b0, end_w});
  assign sts.clr_last   = (&clr_r);
  assign sts.carve_done = (p_r >= end_w);
  assign sts.scan_done  = scan_v_r && (((|scan_m) && (lo_w == want_r)) || (&scan_q_r));
  assign sts.scan_none  = (best_o_r == ORD_W'(NUM_ORDERS));
  assign sts.at_want    = (ord_r == want_r);
  assign sts.at_top     = (ord_r == ORD_W'(TOP_ORDER));
  assign sts.bud_hit    = |(m_rdata & bit_w);
  assign sts.rng_last   = (rw_r == rlast_pg[PAGE_W-1:UW_SH]);
  assign sts.chk_fail   = |(mask_w & ~u_rdata);
  assign sts.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid      = out_tvalid_r;
  assign out_status      = out_status_r;
  assign out_block_page  = out_block_page_r;
  assign out_blk_len     = out_blk_len_r;
  assign out_free_count  = out_free_count_r;

  `BPA_CHECK(a_cnt_range, free_cnt_r <= CNT_W'(MAX_PAGES), "free page counter above page count")
  `BPA_CHECK_NEXT(a_cnt_hold, ctl.cmd != CMD_RNG_REL && ctl.cmd != CMD_CLR_START, $stable(free_cnt_r), "free page counter moved outside a range pass")
  `BPA_CHECK_NEXT(a_scan_best, ctl.cmd == CMD_SCAN_START, best_o_r == ORD_W'(NUM_ORDERS), "scan did not restart its best block")

endmodule

>>> hdl/bpa_ctrl.sv
// ---------------------------------------------------------------------------
// bpa_ctrl
// operation sequencer: clearing pass, init carve, alloc scan/split, free merge
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  logic       carve_r, carve_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      st_r    <= ST_OK;
      carve_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      carve_r <= carve_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    carve_nxt = carve_r;
    unique case (state_r)
      S_CLR: if (sts.clr_last) state_nxt = carve_r ? S_CARVE : S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DEC;
          carve_nxt = 1'b0;
        end
      end
      S_DEC: begin
        state_nxt = S_DONE;
        st_nxt    = ST_IGNORED;
        priority if (sts.func == FN_INIT) begin
          state_nxt = S_CLR;
          carve_nxt = 1'b1;
        end else if (sts.func == FN_ALLOC) begin
          priority if (sts.cnt_zero) st_nxt = ST_IGNORED;
          else if (sts.ord_big) st_nxt = ST_NOSPACE;
          else state_nxt = S_SCAN;
        end else if (sts.func == FN_FREE) begin
          if (!sts.free_bad) state_nxt = S_CHK_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CARVE: begin
        if (sts.carve_done) begin
          state_nxt = S_DONE;
          st_nxt    = ST_OK;
        end else begin
          state_nxt = S_REL_RD;
        end
      end
      S_SCAN: if (sts.scan_done) state_nxt = S_TAKE;
      S_TAKE: begin
        if (sts.scan_none) begin
          state_nxt = S_DONE;
          st_nxt    = ST_NOSPACE;
        end else begin
          state_nxt = S_TAKE_RD;
        end
      end
      S_TAKE_RD:  state_nxt = S_TAKE_WR;
      S_TAKE_WR:  state_nxt = S_SPLIT;
      S_SPLIT:    state_nxt = sts.at_want ? S_USE_RD : S_SPLIT_RD;
      S_SPLIT_RD: state_nxt = S_SPLIT_WR;
      S_SPLIT_WR: state_nxt = S_SPLIT;
      S_CHK_RD:   state_nxt = S_CHK_WR;
      S_CHK_WR: begin
        priority if (sts.chk_fail) begin
          state_nxt = S_DONE;
          st_nxt    = ST_IGNORED;
        end else if (sts.rng_last) begin
          state_nxt = S_REL_RD;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end
      S_REL_RD: state_nxt = S_REL_WR;
      S_REL_WR: begin
        if (sts.rng_last) state_nxt = carve_r ? S_CARVE : S_MERGE;
        else state_nxt = S_REL_RD;
      end
      S_USE_RD: state_nxt = S_USE_WR;
      S_USE_WR: begin
        if (sts.rng_last) begin
          state_nxt = S_DONE;
          st_nxt    = ST_OK;
        end else begin
          state_nxt = S_USE_RD;
        end
      end
      S_MERGE:  state_nxt = sts.at_top ? S_FILE_RD : S_BUD_RD;
      S_BUD_RD: state_nxt = S_BUD_WR;
      S_BUD_WR: state_nxt = sts.bud_hit ? S_MERGE : S_FILE_RD;
      S_FILE_RD: state_nxt = S_FILE_WR;
      S_FILE_WR: begin
        state_nxt = S_DONE;
        st_nxt    = ST_OK;
      end
      S_DONE: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.cmd      = CMD_NONE;
    ctl.tgt      = TGT_SELF;
    ctl.use_pass = 1'b0;
    ctl.st       = st_r;
    in_tready    = 1'b0;
    unique case (state_r)
      S_CLR: ctl.cmd = CMD_CLR_STEP;
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) ctl.cmd = CMD_LOAD;
      end
      S_DEC: begin
        if (sts.func == FN_INIT) ctl.cmd = CMD_CLR_START;
        else if (sts.func == FN_ALLOC) ctl.cmd = CMD_SCAN_START;
        else if (sts.func == FN_FREE) ctl.cmd = CMD_RNG_PG;
      end
      S_CARVE:    if (!sts.carve_done) ctl.cmd = CMD_CARVE_BLOCK;
      S_SCAN:     ctl.cmd = CMD_SCAN_STEP;
      S_TAKE:     if (!sts.scan_none) ctl.cmd = CMD_TAKE;
      S_TAKE_WR:  ctl.cmd = CMD_MWR_CLR;
      S_SPLIT:    ctl.cmd = sts.at_want ? CMD_RNG_BLK : CMD_SPLIT_DEC;
      S_SPLIT_RD: ctl.tgt = TGT_HALF;
      S_SPLIT_WR: begin
        ctl.cmd = CMD_MWR_SET;
        ctl.tgt = TGT_HALF;
      end
      S_CHK_WR: begin
        if (!sts.chk_fail) ctl.cmd = sts.rng_last ? CMD_RNG_PG : CMD_RNG_CHK;
      end
      S_REL_WR: ctl.cmd = CMD_RNG_REL;
      S_USE_WR: begin
        ctl.cmd      = CMD_RNG_REL;
        ctl.use_pass = 1'b1;
      end
      S_BUD_RD: ctl.tgt = TGT_BUDDY;
      S_BUD_WR: begin
        ctl.tgt = TGT_BUDDY;
        if (sts.bud_hit) ctl.cmd = CMD_MERGE;
      end
      S_FILE_WR: ctl.cmd = CMD_MWR_SET;
      S_DONE: begin
        // use_pass with no command raises the result word
        if (sts.out_free) ctl.use_pass = 1'b1;
      end
      default: ;
    endcase
  end

  `BPA_CHECK(a_ready_idle, !in_tready || state_r == S_IDLE, "input taken outside idle")
  `BPA_CHECK_NEXT(a_done_idle, state_r == S_DONE && sts.out_free, state_r == S_IDLE, "result issued but sequencer not idle")
  `BPA_CHECK_NEXT(a_carve_clr, state_r == S_DEC && sts.func == FN_INIT, state_r == S_CLR && carve_r, "init did not start the clearing pass")

endmodule

>>> hdl/buddy_page_allocator.sv
// ---------------------------------------------------------------------------
// buddy_page_allocator
// binary buddy allocator over page numbers, one result word per request
// ---------------------------------------------------------------------------
// usage:
//   in_* takes one request word: init region, allocate or free. every
//   request returns exactly one result word on out_*.
//   cfg_* writes the page limit (index 0) and first_free_page (index 1);
//   write only while no request is in flight. cfg_ready is always high.
//   allocate scans the block marks one page per cycle, then splits the
//   block found down to the wanted order and marks its pages used word by
//   word. free checks, then releases its 16-page used-bit words and merges
//   buddies. init runs a clearing pass, then carves blocks and releases
//   their used-bit words. one request is worked on at a time.
//   after reset the same clearing pass runs before in_tready rises.
//   the result sits in an output register; while the receiver stalls the
//   block still takes the next request and holds its result until the
//   register frees up.
// ---------------------------------------------------------------------------
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // func[1:0], page_count[14:2], page_number[26:15]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], block_page[13:2], blk_len[24:14],
                                  // free_count[37:25]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  ctl_t                ctl;
  sts_t                sts;
  logic [1:0]          out_status;
  logic [PAGE_W-1:0]   out_block_page;
  logic [BLK_W-1:0]    out_blk_len;
  logic [CNT_W-1:0]    out_free_count;

  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .ctl(ctl)
  );

  bpa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_func(in_tdata[1:0]), .in_count(in_tdata[14:2]), .in_page(in_tdata[26:15]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .out_tready(out_tready), .out_tvalid(out_tvalid),
    .out_status(out_status), .out_block_page(out_block_page),
    .out_blk_len(out_blk_len), .out_free_count(out_free_count)
  );

  assign out_tdata = {2'b00, out_free_count, out_blk_len, out_block_page, out_status};

endmodule
